@@ rtl/jsv_pkg.sv @@
`timescale 1ns / 1ps
// Package for the JSON syntax validator: depth limit, parser phases, verdict
// codes and byte class / literal helpers. No dependencies.
package jsv_pkg;

  // Deepest container nesting that a value may start in
  localparam int MAX_DEPTH  = 16;
  // Nesting level counts 0 .. MAX_DEPTH+1
  localparam int LVL_W      = $clog2(MAX_DEPTH + 2);
  // Container kind stack holds MAX_DEPTH+1 entries
  localparam int KIND_DEPTH = MAX_DEPTH + 1;
  localparam int KIND_IDX_W = $clog2(KIND_DEPTH);

  typedef enum logic [4:0] {
    PH_VALUE     = 5'd0,
    PH_ARR_FIRST = 5'd1,
    PH_OBJ_FIRST = 5'd2,
    PH_KEY       = 5'd3,
    PH_COLON     = 5'd4,
    PH_AFTER     = 5'd5,
    PH_TRAIL     = 5'd6,
    PH_STR       = 5'd7,
    PH_STR_ESC   = 5'd8,
    PH_STR_HEX   = 5'd9,
    PH_KEY_STR   = 5'd10,
    PH_KEY_ESC   = 5'd11,
    PH_KEY_HEX   = 5'd12,
    PH_LITERAL   = 5'd13,
    PH_N_MINUS   = 5'd14,
    PH_N_ZERO    = 5'd15,
    PH_N_INT     = 5'd16,
    PH_N_DOT     = 5'd17,
    PH_N_FRAC    = 5'd18,
    PH_N_EXP     = 5'd19,
    PH_N_ESIGN   = 5'd20,
    PH_N_EDIG    = 5'd21
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_VALID   = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2
  } lit_kind_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_simple_escape(input logic [7:0] c);
    return (c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
           (c == "f") || (c == "n") || (c == "r") || (c == "t");
  endfunction

  // Character at a position of true / false / null
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (kind)
      LIT_TRUE: begin
        unique case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_NULL: begin
        unique case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

@@ rtl/jsv_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the JSON syntax validator: one document byte per word.
// No dependencies.
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/jsv_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the JSON syntax validator: one verdict per word.
// No dependencies.
interface jsv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       document_done;

  modport source (output valid, output verdict, output document_done, input ready);
  modport sink   (input valid, input verdict, input document_done, output ready);
endinterface

@@ rtl/json_syntax_validator.sv @@
`timescale 1ns / 1ps
// Streaming JSON syntax validator, top level.
// Uses jsv_pkg, jsv_in_if and jsv_out_if.
//
// Feed the bytes of a document one per input word, with end_of_text set on
// the last one; every byte gives exactly one result word, in the cycle after it
// is taken. verdict reads 0 while the document is still valid so far and 2
// once it is known to be invalid; on the last byte document_done is 1 and
// verdict is 1 (valid) or 2 (invalid), after which the parser is back at its
// reset state for the next document. The block takes one byte every clock:
// the parser phase, nesting level and container-kind stack top are updated
// as the byte is taken and the result sits in one output register, so input
// ready is low only while that register holds a word the sink has not taken.
// Nesting deeper than MAX_DEPTH+1 containers is reported invalid.
module json_syntax_validator
  import jsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jsv_in_if.sink    byte_in,
  jsv_out_if.source result_out
);

  // Parser state
  phase_t            phase, phase_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [2:0]        lit_pos, lit_pos_next;
  logic [1:0]        lit_kind, lit_kind_next;
  logic [2:0]        hex_left, hex_left_next;
  logic              err, err_next;
  logic              kinds [KIND_DEPTH];

  // Result register
  logic              out_valid;
  logic [1:0]        out_verdict, out_verdict_next;
  logic              out_done;

  // Working signals
  logic              accept;
  logic [7:0]        c;
  logic [LVL_W-1:0]  lvl_dec;
  logic              top_obj;
  phase_t            vd_phase, close_phase, ph1;
  logic              do_struct, want_start, kind_we, complete;
  logic [2:0]        lit_pos_inc;

  assign byte_in.ready = !out_valid || result_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign c             = byte_in.text_byte;

  assign lvl_dec     = lvl - LVL_W'(1);
  assign top_obj     = (lvl != '0) ? kinds[lvl_dec[KIND_IDX_W-1:0]] : 1'b0;
  assign vd_phase    = (lvl == '0) ? PH_TRAIL : PH_AFTER;
  assign close_phase = (lvl_dec == '0) ? PH_TRAIL : PH_AFTER;
  assign lit_pos_inc = lit_pos + 3'd1;

  // Next parser state for the byte on the input
  always_comb begin
    phase_next       = phase;
    lvl_next         = lvl;
    lit_pos_next     = lit_pos;
    lit_kind_next    = lit_kind;
    hex_left_next    = hex_left;
    err_next         = err;
    ph1              = phase;
    do_struct        = 1'b1;
    want_start       = 1'b0;
    kind_we          = 1'b0;
    complete         = 1'b0;
    out_verdict_next = VERDICT_PENDING;

    if (!err) begin
      // Number phases: either consume the byte or end the value and fall
      // through to the structural step on the same byte
      unique case (phase)
        PH_N_MINUS: begin
          do_struct = 1'b0;
          if (c == "0") phase_next = PH_N_ZERO;
          else if (is_digit(c)) phase_next = PH_N_INT;
          else err_next = 1'b1;
        end
        PH_N_ZERO: begin
          if (c == ".") begin
            do_struct = 1'b0; phase_next = PH_N_DOT;
          end else if (c == "e" || c == "E") begin
            do_struct = 1'b0; phase_next = PH_N_EXP;
          end else begin
            ph1 = vd_phase; phase_next = vd_phase;
          end
        end
        PH_N_INT: begin
          if (is_digit(c)) begin
            do_struct = 1'b0;
          end else if (c == ".") begin
            do_struct = 1'b0; phase_next = PH_N_DOT;
          end else if (c == "e" || c == "E") begin
            do_struct = 1'b0; phase_next = PH_N_EXP;
          end else begin
            ph1 = vd_phase; phase_next = vd_phase;
          end
        end
        PH_N_DOT: begin
          do_struct = 1'b0;
          if (is_digit(c)) phase_next = PH_N_FRAC;
          else err_next = 1'b1;
        end
        PH_N_FRAC: begin
          if (is_digit(c)) begin
            do_struct = 1'b0;
          end else if (c == "e" || c == "E") begin
            do_struct = 1'b0; phase_next = PH_N_EXP;
          end else begin
            ph1 = vd_phase; phase_next = vd_phase;
          end
        end
        PH_N_EXP: begin
          do_struct = 1'b0;
          if (c == "+" || c == "-") phase_next = PH_N_ESIGN;
          else if (is_digit(c)) phase_next = PH_N_EDIG;
          else err_next = 1'b1;
        end
        PH_N_ESIGN: begin
          do_struct = 1'b0;
          if (is_digit(c)) phase_next = PH_N_EDIG;
          else err_next = 1'b1;
        end
        PH_N_EDIG: begin
          if (is_digit(c)) begin
            do_struct = 1'b0;
          end else begin
            ph1 = vd_phase; phase_next = vd_phase;
          end
        end
        default: ;
      endcase

      // Structural and string phases
      if (do_struct) begin
        unique case (ph1)
          PH_VALUE: begin
            if (!is_ws(c)) want_start = 1'b1;
          end
          PH_ARR_FIRST: begin
            if (!is_ws(c)) begin
              if (c == "]") begin
                lvl_next = lvl_dec; phase_next = close_phase;
              end else begin
                want_start = 1'b1;
              end
            end
          end
          PH_OBJ_FIRST: begin
            if (!is_ws(c)) begin
              if (c == "}") begin
                lvl_next = lvl_dec; phase_next = close_phase;
              end else if (c == "\"") phase_next = PH_KEY_STR;
              else err_next = 1'b1;
            end
          end
          PH_KEY: begin
            if (!is_ws(c)) begin
              if (c == "\"") phase_next = PH_KEY_STR;
              else err_next = 1'b1;
            end
          end
          PH_COLON: begin
            if (!is_ws(c)) begin
              if (c == ":") phase_next = PH_VALUE;
              else err_next = 1'b1;
            end
          end
          PH_AFTER: begin
            if (!is_ws(c)) begin
              if (lvl == '0 || lvl > LVL_W'(MAX_DEPTH + 1)) err_next = 1'b1;
              else if (c == ",") phase_next = top_obj ? PH_KEY : PH_VALUE;
              else if ((top_obj && c == "}") || (!top_obj && c == "]")) begin
                lvl_next = lvl_dec; phase_next = close_phase;
              end else err_next = 1'b1;
            end
          end
          PH_TRAIL: begin
            if (!is_ws(c)) err_next = 1'b1;
          end
          PH_STR, PH_KEY_STR: begin
            if (c == "\"") phase_next = (ph1 == PH_KEY_STR) ? PH_COLON : vd_phase;
            else if (c < 8'h20) err_next = 1'b1;
            else if (c == "\\") phase_next = (ph1 == PH_KEY_STR) ? PH_KEY_ESC : PH_STR_ESC;
          end
          PH_STR_ESC, PH_KEY_ESC: begin
            if (c == "u") begin
              hex_left_next = 3'd4;
              phase_next    = (ph1 == PH_KEY_ESC) ? PH_KEY_HEX : PH_STR_HEX;
            end else if (is_simple_escape(c)) begin
              phase_next = (ph1 == PH_KEY_ESC) ? PH_KEY_STR : PH_STR;
            end else err_next = 1'b1;
          end
          PH_STR_HEX, PH_KEY_HEX: begin
            if (!is_hex(c)) begin
              err_next = 1'b1;
            end else begin
              if (hex_left != 3'd0) hex_left_next = hex_left - 3'd1;
              if (hex_left <= 3'd1) phase_next = (ph1 == PH_KEY_HEX) ? PH_KEY_STR : PH_STR;
            end
          end
          PH_LITERAL: begin
            if (lit_kind == 2'd3 || lit_pos >= lit_len(lit_kind) ||
                c != lit_char(lit_kind, lit_pos)) begin
              err_next = 1'b1;
            end else begin
              lit_pos_next = lit_pos_inc;
              if (lit_pos_inc == lit_len(lit_kind)) phase_next = vd_phase;
            end
          end
          default: err_next = 1'b1;
        endcase
      end

      // Start of a new value
      if (want_start) begin
        if (lvl > LVL_W'(MAX_DEPTH)) err_next = 1'b1;
        else if (c == "\"") phase_next = PH_STR;
        else if (c == "{" || c == "[") begin
          kind_we    = 1'b1;
          lvl_next   = lvl + LVL_W'(1);
          phase_next = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
        end else if (c == "t" || c == "f" || c == "n") begin
          lit_kind_next = (c == "t") ? LIT_TRUE : ((c == "f") ? LIT_FALSE : LIT_NULL);
          lit_pos_next  = 3'd1;
          phase_next    = PH_LITERAL;
        end else if (c == "-") phase_next = PH_N_MINUS;
        else if (c == "0") phase_next = PH_N_ZERO;
        else if (c >= "1" && c <= "9") phase_next = PH_N_INT;
        else err_next = 1'b1;
      end
    end

    // Verdict, and return to reset state at the end of a document
    if (byte_in.end_of_text) begin
      complete = (phase_next == PH_TRAIL) ||
                 ((lvl_next == '0) &&
                  (phase_next == PH_N_ZERO || phase_next == PH_N_INT ||
                   phase_next == PH_N_FRAC || phase_next == PH_N_EDIG));
      out_verdict_next = (!err_next && complete) ? VERDICT_VALID : VERDICT_INVALID;
      phase_next       = PH_VALUE;
      lvl_next         = '0;
      lit_pos_next     = 3'd0;
      lit_kind_next    = 2'd0;
      hex_left_next    = 3'd0;
      err_next         = 1'b0;
    end else begin
      out_verdict_next = err_next ? VERDICT_INVALID : VERDICT_PENDING;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_VALUE;
      lvl      <= '0;
      lit_pos  <= 3'd0;
      lit_kind <= 2'd0;
      hex_left <= 3'd0;
      err      <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      lvl      <= lvl_next;
      lit_pos  <= lit_pos_next;
      lit_kind <= lit_kind_next;
      hex_left <= hex_left_next;
      err      <= err_next;
    end
  end

  // Container kind stack: written when a container opens
  always_ff @(posedge clk) begin
    if (accept && kind_we) begin
      kinds[lvl[KIND_IDX_W-1:0]] <= (c == "{");
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_verdict <= out_verdict_next;
      out_done    <= byte_in.end_of_text;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.verdict       = out_verdict;
  assign result_out.document_done = out_done;

endmodule

@@ rtl/jsv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the JSON syntax validator, bound to its top level.
// Uses jsv_pkg; attached to json_syntax_validator.
module jsv_checker
  import jsv_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] verdict,
  input logic       document_done
);

  // Every accepted byte shows up as a result word on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted byte produced no result word");

  // A stalled result blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while result word is stalled");

  // A valid verdict only comes with the end of a document
  a_valid_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_VALID) |-> document_done)
    else $error("valid verdict before end of document");

  // A stalled result word holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(document_done)))
    else $error("stalled result word changed");

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .verdict       (result_out.verdict),
  .document_done (result_out.document_done)
);

@@ dv/json_syntax_validator_tb.sv @@
`timescale 1ns / 1ps
// Testbench for json_syntax_validator: streams directed and generated JSON
// documents one byte per word and checks every verdict word against a local
// parser model. Depends on jsv_pkg, jsv_in_if, jsv_out_if and the RTL top.
module json_syntax_validator_tb;
  import jsv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 950;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT     = 24;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef struct packed {
    verdict_t verdict;
    logic     document_done;
  } verdict_word_t;

  logic clk;
  logic rst;

  jsv_in_if  byte_in ();
  jsv_out_if result_out ();

  json_syntax_validator dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .result_out (result_out)
  );

  // Verdicts still owed by the block, oldest first
  verdict_word_t verdicts_due[$];
  int unsigned   mismatches;
  int unsigned   cycle_count;
  int unsigned   bytes_sent;
  logic          calm;        // no idling on either side while set
  logic [7:0]    doc_text[$]; // document being assembled

  // Parser model state
  logic [KIND_DEPTH-1:0] open_is_obj;
  logic [LVL_W-1:0]      open_count;
  phase_t                pstate;
  logic [2:0]            lit_pos;
  lit_kind_t             lit_sel;
  logic [2:0]            hex_owed;
  logic                  doc_bad;

  string lit_words[3] = '{"true", "false", "null"};
  string simple_escs  = "\"\\/bfnrt";
  string hex_chars    = "0123456789abcdefABCDEF";

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic logic blank_byte(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic dec_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic hex_digit(logic [7:0] c);
    return dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic plain_escape(logic [7:0] c);
    return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t";
  endfunction

  function automatic void model_reset();
    open_is_obj = '0;
    open_count  = '0;
    pstate      = PH_VALUE;
    lit_pos     = '0;
    lit_sel     = LIT_TRUE;
    hex_owed    = '0;
    doc_bad     = 1'b0;
  endfunction

  function automatic void value_closed();
    pstate = (open_count == 0) ? PH_TRAIL : PH_AFTER;
  endfunction

  function automatic void close_one();
    open_count = open_count - 1'b1;
    value_closed();
  endfunction

  // First byte of a value; too many open containers kills the document
  function automatic void begin_value(logic [7:0] c);
    if (open_count > MAX_DEPTH) begin
      doc_bad = 1'b1;
      return;
    end
    if (c == "\"") begin
      pstate = PH_STR;
    end else if (c == "{" || c == "[") begin
      open_is_obj[open_count] = (c == "{");
      open_count = open_count + 1'b1;
      pstate = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
    end else if (c == "t" || c == "f" || c == "n") begin
      lit_sel = (c == "t") ? LIT_TRUE : ((c == "f") ? LIT_FALSE : LIT_NULL);
      lit_pos = 3'd1;
      pstate  = PH_LITERAL;
    end else if (c == "-") begin
      pstate = PH_N_MINUS;
    end else if (c == "0") begin
      pstate = PH_N_ZERO;
    end else if (c >= "1" && c <= "9") begin
      pstate = PH_N_INT;
    end else begin
      doc_bad = 1'b1;
    end
  endfunction

  function automatic void string_char(logic [7:0] c, logic key);
    if (c == "\"") begin
      if (key) pstate = PH_COLON;
      else value_closed();
    end else if (c < 8'h20) begin
      doc_bad = 1'b1;
    end else if (c == "\\") begin
      pstate = key ? PH_KEY_ESC : PH_STR_ESC;
    end
  endfunction

  function automatic void escape_char(logic [7:0] c, logic key);
    if (c == "u") begin
      hex_owed = 3'd4;
      pstate   = key ? PH_KEY_HEX : PH_STR_HEX;
    end else if (plain_escape(c)) begin
      pstate = key ? PH_KEY_STR : PH_STR;
    end else begin
      doc_bad = 1'b1;
    end
  endfunction

  function automatic void hex_char(logic [7:0] c, logic key);
    if (!hex_digit(c)) begin
      doc_bad = 1'b1;
      return;
    end
    if (hex_owed > 0) hex_owed = hex_owed - 1'b1;
    if (hex_owed == 0) pstate = key ? PH_KEY_STR : PH_STR;
  endfunction

  // Structure, strings and literals
  function automatic void grammar_step(logic [7:0] c);
    logic in_obj;
    case (pstate)
      PH_VALUE: begin
        if (!blank_byte(c)) begin_value(c);
      end
      PH_ARR_FIRST: begin
        if (!blank_byte(c)) begin
          if (c == "]") close_one();
          else begin_value(c);
        end
      end
      PH_OBJ_FIRST: begin
        if (!blank_byte(c)) begin
          if (c == "}") close_one();
          else if (c == "\"") pstate = PH_KEY_STR;
          else doc_bad = 1'b1;
        end
      end
      PH_KEY: begin
        if (!blank_byte(c)) begin
          if (c == "\"") pstate = PH_KEY_STR;
          else doc_bad = 1'b1;
        end
      end
      PH_COLON: begin
        if (!blank_byte(c)) begin
          if (c == ":") pstate = PH_VALUE;
          else doc_bad = 1'b1;
        end
      end
      PH_AFTER: begin
        if (!blank_byte(c)) begin
          if (open_count == 0 || open_count > MAX_DEPTH + 1) begin
            doc_bad = 1'b1;
          end else begin
            in_obj = open_is_obj[open_count - 1'b1];
            if (c == ",") pstate = in_obj ? PH_KEY : PH_VALUE;
            else if ((in_obj && c == "}") || (!in_obj && c == "]")) close_one();
            else doc_bad = 1'b1;
          end
        end
      end
      PH_TRAIL: begin
        if (!blank_byte(c)) doc_bad = 1'b1;
      end
      PH_STR:     string_char(c, 1'b0);
      PH_STR_ESC: escape_char(c, 1'b0);
      PH_STR_HEX: hex_char(c, 1'b0);
      PH_KEY_STR: string_char(c, 1'b1);
      PH_KEY_ESC: escape_char(c, 1'b1);
      PH_KEY_HEX: hex_char(c, 1'b1);
      PH_LITERAL: begin
        if (lit_pos >= lit_words[lit_sel].len() || c != lit_words[lit_sel][lit_pos]) begin
          doc_bad = 1'b1;
        end else begin
          lit_pos = lit_pos + 1'b1;
          if (lit_pos == lit_words[lit_sel].len()) value_closed();
        end
      end
      default: doc_bad = 1'b1;
    endcase
  endfunction

  // Number phases; a byte that ends a number is handed on to the grammar
  function automatic void number_step(logic [7:0] c);
    logic dig;
    logic ex;
    dig = dec_digit(c);
    ex  = (c == "e" || c == "E");
    case (pstate)
      PH_N_MINUS: begin
        if (c == "0") pstate = PH_N_ZERO;
        else if (dig) pstate = PH_N_INT;
        else doc_bad = 1'b1;
        return;
      end
      PH_N_ZERO: begin
        if (c == ".") begin
          pstate = PH_N_DOT;
          return;
        end
        if (ex) begin
          pstate = PH_N_EXP;
          return;
        end
        value_closed();
      end
      PH_N_INT: begin
        if (dig) return;
        if (c == ".") begin
          pstate = PH_N_DOT;
          return;
        end
        if (ex) begin
          pstate = PH_N_EXP;
          return;
        end
        value_closed();
      end
      PH_N_DOT: begin
        if (dig) pstate = PH_N_FRAC;
        else doc_bad = 1'b1;
        return;
      end
      PH_N_FRAC: begin
        if (dig) return;
        if (ex) begin
          pstate = PH_N_EXP;
          return;
        end
        value_closed();
      end
      PH_N_EXP: begin
        if (c == "+" || c == "-") pstate = PH_N_ESIGN;
        else if (dig) pstate = PH_N_EDIG;
        else doc_bad = 1'b1;
        return;
      end
      PH_N_ESIGN: begin
        if (dig) pstate = PH_N_EDIG;
        else doc_bad = 1'b1;
        return;
      end
      PH_N_EDIG: begin
        if (dig) return;
        value_closed();
      end
      default: ;
    endcase
    grammar_step(c);
  endfunction

  function automatic verdict_word_t predict_verdict(logic [7:0] c, logic last);
    verdict_word_t w;
    logic complete;
    // Once broken, the rest of the document is ignored up to its end mark
    if (!doc_bad) number_step(c);
    if (last) begin
      complete = (pstate == PH_TRAIL) ||
                 (open_count == 0 &&
                  pstate inside {PH_N_ZERO, PH_N_INT, PH_N_FRAC, PH_N_EDIG});
      w.verdict       = (!doc_bad && complete) ? VERDICT_VALID : VERDICT_INVALID;
      w.document_done = 1'b1;
      model_reset();
    end else begin
      w.verdict       = doc_bad ? VERDICT_INVALID : VERDICT_PENDING;
      w.document_done = 1'b0;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte channel driver, result sink and checker
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic last);
    logic taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid       <= 1'b1;
    byte_in.text_byte   <= c;
    byte_in.end_of_text <= last;
    // ready is stable between edges, so the mid-cycle sample holds at the edge
    do begin
      @(negedge clk);
      taken = byte_in.ready;
      @(posedge clk);
    end while (!taken);
    verdicts_due.push_back(predict_verdict(c, last));
    bytes_sent++;
  endtask

  always @(posedge clk) begin
    result_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // A word seen with valid and ready mid-cycle is taken at the next edge
  always @(negedge clk) begin
    verdict_word_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $error("unexpected result word: verdict %0d document_done %0d",
               result_out.verdict, result_out.document_done);
      end else begin
        want = verdicts_due.pop_front();
        if (result_out.verdict !== want.verdict) begin
          mismatches++;
          $error("verdict: expected %0d, actual %0d", want.verdict, result_out.verdict);
        end
        if (result_out.document_done !== want.document_done) begin
          mismatches++;
          $error("document_done: expected %0d, actual %0d",
                 want.document_done, result_out.document_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Document assembly
  // ---------------------------------------------------------------------------
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
  endfunction

  task automatic send_doc();
    for (int i = 0; i < doc_text.size(); i++) send_byte(doc_text[i], i == doc_text.size() - 1);
    doc_text.delete();
  endtask

  task automatic send_text(string s);
    put_str(s);
    send_doc();
  endtask

  function automatic void put_blank();
    case ($urandom_range(7))
      0: doc_text.push_back(CH_SP);
      1: doc_text.push_back(CH_TAB);
      2: doc_text.push_back(CH_CR);
      3: doc_text.push_back(CH_LF);
      default: ;
    endcase
  endfunction

  function automatic void put_digits(int unsigned n);
    repeat (n) doc_text.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void put_string();
    logic [7:0] c;
    doc_text.push_back("\"");
    repeat ($urandom_range(4)) begin
      case ($urandom_range(5))
        0, 1: begin
          c = 8'($urandom_range(8'h7E, 8'h20));
          doc_text.push_back((c == "\"" || c == "\\") ? 8'h5F : c);
        end
        2: doc_text.push_back(8'($urandom_range(8'hFF, 8'h80)));
        3: begin
          doc_text.push_back("\\");
          doc_text.push_back(simple_escs[$urandom_range(7)]);
        end
        default: begin
          put_str("\\u");
          repeat (4) doc_text.push_back(hex_chars[$urandom_range(21)]);
        end
      endcase
    end
    doc_text.push_back("\"");
  endfunction

  function automatic void put_number();
    if ($urandom_range(1)) doc_text.push_back("-");
    if ($urandom_range(3) == 0) begin
      doc_text.push_back("0");
    end else begin
      doc_text.push_back(8'("1" + $urandom_range(8)));
      put_digits($urandom_range(2));
    end
    if ($urandom_range(2) == 0) begin
      doc_text.push_back(".");
      put_digits($urandom_range(3, 1));
    end
    if ($urandom_range(2) == 0) begin
      doc_text.push_back($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: doc_text.push_back("+");
        1: doc_text.push_back("-");
        default: ;
      endcase
      put_digits($urandom_range(2, 1));
    end
  endfunction

  function automatic void put_scalar();
    case ($urandom_range(2))
      0: put_string();
      1: put_number();
      default: put_str(lit_words[$urandom_range(2)]);
    endcase
  endfunction

  function automatic void put_key();
    put_string();
    put_blank();
    doc_text.push_back(":");
    put_blank();
  endfunction

  // Well-formed document built with an explicit container stack; deep ones
  // are single-child chains that may run past the nesting limit
  function automatic void build_doc(logic deep);
    logic        stack_obj[$];
    int unsigned items_left[$];
    logic        want_value;
    logic        finished;
    int unsigned nest_cap;
    int unsigned n;
    int unsigned top;
    nest_cap   = deep ? $urandom_range(19, 12) : 3;
    want_value = 1'b1;
    finished   = 1'b0;
    put_blank();
    while (!finished) begin
      if (want_value) begin
        if (stack_obj.size() < nest_cap && $urandom_range(99) < (deep ? 90 : 35)) begin
          n = deep ? 1 : $urandom_range(3);
          stack_obj.push_back(1'($urandom_range(1)));
          items_left.push_back(n);
          top = stack_obj.size() - 1;
          doc_text.push_back(stack_obj[top] ? "{" : "[");
          put_blank();
          if (n == 0) begin
            doc_text.push_back(stack_obj[top] ? "}" : "]");
            void'(stack_obj.pop_back());
            void'(items_left.pop_back());
            want_value = 1'b0;
          end else if (stack_obj[top]) begin
            put_key();
          end
        end else begin
          put_scalar();
          want_value = 1'b0;
        end
        put_blank();
      end else if (stack_obj.size() == 0) begin
        finished = 1'b1;
      end else begin
        top = stack_obj.size() - 1;
        items_left[top] = items_left[top] - 1;
        if (items_left[top] > 0) begin
          doc_text.push_back(",");
          put_blank();
          if (stack_obj[top]) put_key();
          want_value = 1'b1;
        end else begin
          doc_text.push_back(stack_obj[top] ? "}" : "]");
          put_blank();
          void'(stack_obj.pop_back());
          void'(items_left.pop_back());
        end
      end
    end
  endfunction

  // Break an assembled document in one place
  function automatic void damage_doc();
    int unsigned at;
    string breakers;
    breakers = "{}[],:\"\\";
    at = $urandom_range(doc_text.size() - 1);
    case ($urandom_range(4))
      0: doc_text[at] = 8'($urandom);
      1: doc_text[at] = breakers[$urandom_range(7)];
      2: while (doc_text.size() > at + 1) void'(doc_text.pop_back());
      3: doc_text.insert(at, 8'($urandom));
      default: doc_text.push_back(breakers[$urandom_range(7)]);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_literals();
    send_text("true");
    send_text("false");
    send_text(" null\n");
    send_text("nul");
    send_text("trux");
  endtask

  task automatic test_numbers();
    send_text("7");
    send_text("0");
    send_text("-0.5e+10");
    send_text("12E-3 ");
    send_text("01");
    send_text("-");
    send_text("1.");
    send_text("2e");
    send_text("-x");
    send_text("[0,-1,2.5e1]");
  endtask

  task automatic test_strings();
    send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\\u09aF\"");
    // raw control byte, then the first byte that is allowed
    put_str("\"a");
    doc_text.push_back(8'h1F);
    put_str("\"");
    send_doc();
    put_str("\" ");
    doc_text.push_back(8'h7F);
    doc_text.push_back(8'h80);
    doc_text.push_back(8'hFF);
    put_str("\"");
    send_doc();
    send_text("\"\\x\"");
    send_text("\"\\u12g4\"");
    send_text("\"abc");
    send_text("{\"k\\u0041\\n\":1}");
  endtask

  task automatic test_containers();
    send_text("{}");
    send_text("[ ]");
    send_text("{\"k\":[1,{}],\"q\":null}");
    send_text("[1,]");
    send_text("{\"a\":1,}");
    send_text("[}");
    send_text("{]");
    send_text("{1:2}");
    send_text("{\"a\" 1}");
    send_text("[1 2]");
    send_text("]");
    // error early, more bytes after it before the end mark
    send_text("[x]  ]]]");
  endtask

  task automatic test_whitespace();
    doc_text.push_back(CH_SP);
    doc_text.push_back(CH_TAB);
    doc_text.push_back(CH_CR);
    doc_text.push_back(CH_LF);
    send_doc();
    send_text(" \n{ } \t");
    send_text("1 2");
    put_str("\"x\"");
    doc_text.push_back(CH_CR);
    send_doc();
  endtask

  task automatic test_depth();
    // deepest legal nesting of arrays
    repeat (MAX_DEPTH + 1) doc_text.push_back("[");
    repeat (MAX_DEPTH + 1) doc_text.push_back("]");
    send_doc();
    // one container too many
    repeat (MAX_DEPTH + 2) doc_text.push_back("[");
    repeat (MAX_DEPTH + 2) doc_text.push_back("]");
    send_doc();
    // scalar inside the deepest container
    repeat (MAX_DEPTH + 1) doc_text.push_back("[");
    doc_text.push_back("0");
    repeat (MAX_DEPTH + 1) doc_text.push_back("]");
    send_doc();
    // alternating kinds, each close must match its opener
    repeat (MAX_DEPTH / 2) put_str("{\"k\":[");
    put_str("true");
    repeat (MAX_DEPTH / 2) put_str("],\"z\":0}");
    send_doc();
    repeat (MAX_DEPTH / 2) put_str("{\"k\":[");
    put_str("true");
    repeat (MAX_DEPTH / 2) put_str("}]");
    send_doc();
  endtask

  task automatic test_random();
    int unsigned goal;
    int unsigned roll;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      // long stretch with no idling early in the run
      calm = (bytes_sent + 900 >= goal) && (bytes_sent + 600 < goal);
      roll = $urandom_range(99);
      if (roll < 6) begin
        repeat ($urandom_range(8, 1)) doc_text.push_back(8'($urandom));
      end else begin
        build_doc(roll < 16);
        if ($urandom_range(99) < 25) damage_doc();
      end
      send_doc();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    byte_in.valid       = 1'b0;
    byte_in.text_byte   = '0;
    byte_in.end_of_text = 1'b0;
    result_out.ready    = 1'b0;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_literals();
    test_numbers();
    test_strings();
    test_containers();
    test_whitespace();
    test_depth();
    test_random();

    byte_in.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jsv_pkg.sv
rtl/jsv_in_if.sv
rtl/jsv_out_if.sv
rtl/json_syntax_validator.sv
rtl/jsv_checker.sv
dv/json_syntax_validator_tb.sv
